// File: design/ptu_pkg.sv
// ptu_pkg: shared types and constants for the particle table update core
// entry layout, configuration bundle, action and register codes; no dependencies

package ptu_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OUT_CNT_W = 7;
  localparam int CMP_W    = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;

  localparam int POS_W  = 32;
  localparam int VEL_W  = 24;
  localparam int LIFE_W = 17;
  localparam int RATE_W = 17;
  localparam int SIZE_W = 16;
  localparam int KIND_W = 2;
  localparam int DT_W   = 16;
  localparam int CFG_W  = 16;
  localparam int ACT_W  = 2;
  localparam int RIDX_W = 6;
  localparam int CIDX_W = 2;

  localparam logic [LIFE_W-1:0] LIFE_FULL = LIFE_W'(65536);

  localparam logic [ACT_W-1:0] ACT_TICK   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd3;

  localparam logic [KIND_W-1:0] KIND_FOAM = 2'd1;

  localparam logic [CIDX_W-1:0] REG_VELOCITY_KEEP = 2'd0;
  localparam logic [CIDX_W-1:0] REG_FOAM_SHRINK   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_MIN_SIZE      = 2'd2;

  localparam logic [CFG_W-1:0] VELOCITY_KEEP_RST = 16'd64225;
  localparam logic [CFG_W-1:0] FOAM_SHRINK_RST   = 16'd65208;
  localparam logic [CFG_W-1:0] MIN_SIZE_RST      = 16'd128;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic [LIFE_W-1:0]       life;
    logic [RATE_W-1:0]       rate;
    logic [SIZE_W-1:0]       size;
    logic [KIND_W-1:0]       kind;
  } entry_t;

  typedef struct packed {
    logic [CFG_W-1:0] velocity_keep;
    logic [CFG_W-1:0] foam_shrink;
    logic [CFG_W-1:0] min_size;
  } cfg_t;

endpackage

// File: design/ptu_update.sv
// ptu_update: two-stage euler step for one particle entry
// stage one registers the products, stage two rounds, saturates and decides survival; uses ptu_pkg

module ptu_update (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  ptu_pkg::entry_t               in_ent,
  input  logic [ptu_pkg::DT_W-1:0]      dt,
  input  ptu_pkg::cfg_t                 cfg,
  output logic                          out_vld,
  output ptu_pkg::entry_t               out_ent,
  output logic                          out_keep
);

  logic                  s1_vld_r;
  ptu_pkg::entry_t       ent_r;
  logic [32:0]           dec_p_r;
  logic signed [40:0]    px_p_r;
  logic signed [40:0]    py_p_r;
  logic signed [40:0]    vx_p_r;
  logic signed [40:0]    vy_p_r;
  logic [31:0]           sz_p_r;

  logic signed [40:0]    dt_s;
  logic signed [40:0]    keep_s;

  logic [33:0]           dec_sum;
  logic [17:0]           dec;
  logic [ptu_pkg::LIFE_W-1:0] new_life;
  logic signed [41:0]    stx_sum;
  logic signed [41:0]    sty_sum;
  logic signed [32:0]    nx_sum;
  logic signed [32:0]    ny_sum;
  logic signed [41:0]    vx_sum;
  logic signed [41:0]    vy_sum;
  logic [32:0]           sz_sum;
  logic [ptu_pkg::SIZE_W-1:0] new_size;

  assign dt_s   = 41'($signed({1'b0, dt}));
  assign keep_s = 41'($signed({1'b0, cfg.velocity_keep}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld) begin
      ent_r   <= in_ent;
      dec_p_r <= 33'(dt) * 33'(in_ent.rate);
      px_p_r  <= 41'(in_ent.vel_x) * dt_s;
      py_p_r  <= 41'(in_ent.vel_y) * dt_s;
      vx_p_r  <= 41'(in_ent.vel_x) * keep_s;
      vy_p_r  <= 41'(in_ent.vel_y) * keep_s;
      sz_p_r  <= 32'(in_ent.size) * 32'(cfg.foam_shrink);
    end
  end

  // round half up then drop 16 fraction bits
  always_comb begin
    dec_sum = 34'(dec_p_r) + 34'd32768;
    dec     = dec_sum[33:16];
    if (dec >= 18'(ent_r.life)) begin
      new_life = '0;
    end else begin
      new_life = ent_r.life - dec[ptu_pkg::LIFE_W-1:0];
    end

    stx_sum = 42'(px_p_r) + 42'sd32768;
    sty_sum = 42'(py_p_r) + 42'sd32768;
    nx_sum  = 33'(ent_r.pos_x) + 33'($signed(stx_sum[41:16]));
    ny_sum  = 33'(ent_r.pos_y) + 33'($signed(sty_sum[41:16]));

    vx_sum = 42'(vx_p_r) + 42'sd32768;
    vy_sum = 42'(vy_p_r) + 42'sd32768;

    sz_sum = 33'(sz_p_r) + 33'd32768;
    if (ent_r.kind == ptu_pkg::KIND_FOAM) begin
      new_size = sz_sum[31:16];
    end else begin
      new_size = ent_r.size;
    end

    out_ent      = ent_r;
    out_ent.life = new_life;
    out_ent.size = new_size;
    out_ent.vel_x = vx_sum[39:16];
    out_ent.vel_y = vy_sum[39:16];
    // saturate to 32-bit signed
    if (nx_sum[32] != nx_sum[31]) begin
      out_ent.pos_x = nx_sum[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      out_ent.pos_x = nx_sum[31:0];
    end
    if (ny_sum[32] != ny_sum[31]) begin
      out_ent.pos_y = ny_sum[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      out_ent.pos_y = ny_sum[31:0];
    end
  end

  assign out_vld  = s1_vld_r;
  assign out_keep = (new_life != '0) && (new_size >= cfg.min_size);

endmodule

// File: design/particle_table_update_core.sv
// particle_table_update_core: top level of the particle table with its entry memory
// uses ptu_pkg and ptu_update
//
// One transaction is handled at a time. Insert, clear, read and a tick of an empty table go
// from idle to the finish state, which loads their result into the output register, and the
// next transaction can be accepted once the state is back in idle. A tick of live entries
// goes through the tick and drain states first: every entry passes once through the single
// read port of the entry memory and then the two-stage update pipeline, with survivors
// written back compacted behind the read pointer. A finished result waits in the output
// register while the next transaction is accepted; if that one finishes while the earlier
// result is still stalled, it waits and the input stays stalled. The memory holds no reset
// state: only entries below the live count are ever read, so no clearing pass is needed.

module particle_table_update_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ptu_pkg::ACT_W-1:0]         in_action,
  input  logic [ptu_pkg::DT_W-1:0]          in_step_time,
  input  logic signed [ptu_pkg::POS_W-1:0]  in_start_x,
  input  logic signed [ptu_pkg::POS_W-1:0]  in_start_y,
  input  logic signed [ptu_pkg::VEL_W-1:0]  in_speed_x,
  input  logic signed [ptu_pkg::VEL_W-1:0]  in_speed_y,
  input  logic [ptu_pkg::RATE_W-1:0]        in_fade_rate,
  input  logic [ptu_pkg::SIZE_W-1:0]        in_start_size,
  input  logic [ptu_pkg::KIND_W-1:0]        in_kind,
  input  logic [ptu_pkg::RIDX_W-1:0]        in_entry_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_accepted,
  output logic [ptu_pkg::OUT_CNT_W-1:0]     out_live_count,
  output logic                              out_entry_valid,
  output logic signed [ptu_pkg::POS_W-1:0]  out_x,
  output logic signed [ptu_pkg::POS_W-1:0]  out_y,
  output logic [ptu_pkg::LIFE_W-1:0]        out_life,
  output logic [ptu_pkg::SIZE_W-1:0]        out_size,
  output logic [ptu_pkg::KIND_W-1:0]        out_kind,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ptu_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [ptu_pkg::CFG_W-1:0]         cfg_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_TICK  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  ptu_pkg::entry_t mem [ptu_pkg::CAPACITY];

  logic [1:0]                  state_r;
  logic [1:0]                  state_nxt;
  logic [ptu_pkg::CNT_W-1:0]   count_r;
  logic [ptu_pkg::CNT_W-1:0]   rd_ptr_r;
  logic [ptu_pkg::CNT_W-1:0]   wr_ptr_r;
  logic [ptu_pkg::DT_W-1:0]    dt_r;
  logic [ptu_pkg::ACT_W-1:0]   act_r;
  logic                        acc_r;
  logic                        hit_r;
  logic                        rd_vld_r;
  logic                        out_valid_r;
  ptu_pkg::cfg_t               cfg_r;
  ptu_pkg::entry_t             rd_q_r;

  logic                        in_acc;
  logic                        full;
  logic                        fin_go;
  logic                        rd_en;
  logic [ptu_pkg::IDX_W-1:0]   rd_addr;
  logic                        wr_en;
  logic [ptu_pkg::IDX_W-1:0]   wr_addr;
  ptu_pkg::entry_t             wr_data;
  ptu_pkg::entry_t             ins_ent;
  logic                        upd_vld;
  ptu_pkg::entry_t             upd_ent;
  logic                        upd_keep;
  logic                        rd_hit;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign full      = (count_r == ptu_pkg::CNT_W'(ptu_pkg::CAPACITY));
  assign fin_go    = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  assign rd_hit    = ptu_pkg::CMP_W'(in_entry_index) < ptu_pkg::CMP_W'(count_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.velocity_keep <= ptu_pkg::VELOCITY_KEEP_RST;
      cfg_r.foam_shrink   <= ptu_pkg::FOAM_SHRINK_RST;
      cfg_r.min_size      <= ptu_pkg::MIN_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ptu_pkg::REG_VELOCITY_KEEP: cfg_r.velocity_keep <= cfg_data;
        ptu_pkg::REG_FOAM_SHRINK:   cfg_r.foam_shrink   <= cfg_data;
        ptu_pkg::REG_MIN_SIZE:      cfg_r.min_size      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_action == ptu_pkg::ACT_TICK && count_r != '0) begin
            state_nxt = S_TICK;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_TICK: begin
        if (rd_ptr_r == count_r - ptu_pkg::CNT_W'(1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_vld_r && !upd_vld) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == S_TICK);
      if (in_acc && in_action == ptu_pkg::ACT_INSERT && !full) begin
        count_r <= count_r + ptu_pkg::CNT_W'(1);
      end else if (in_acc && in_action == ptu_pkg::ACT_CLEAR) begin
        count_r <= '0;
      end else if (state_r == S_DRAIN && state_nxt == S_FIN) begin
        count_r <= wr_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r    <= in_action;
      acc_r    <= (in_action == ptu_pkg::ACT_INSERT) && !full;
      hit_r    <= (in_action == ptu_pkg::ACT_READ) && rd_hit;
      dt_r     <= in_step_time;
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
    end else begin
      if (state_r == S_TICK) begin
        rd_ptr_r <= rd_ptr_r + ptu_pkg::CNT_W'(1);
      end
      if (upd_vld && upd_keep) begin
        wr_ptr_r <= wr_ptr_r + ptu_pkg::CNT_W'(1);
      end
    end
  end

  // entry memory: one read port, one write port
  always_comb begin
    ins_ent.pos_x = in_start_x;
    ins_ent.pos_y = in_start_y;
    ins_ent.vel_x = in_speed_x;
    ins_ent.vel_y = in_speed_y;
    ins_ent.life  = ptu_pkg::LIFE_FULL;
    ins_ent.rate  = in_fade_rate;
    ins_ent.size  = in_start_size;
    ins_ent.kind  = in_kind;

    rd_en   = 1'b0;
    rd_addr = ptu_pkg::IDX_W'(rd_ptr_r);
    if (state_r == S_TICK) begin
      rd_en = 1'b1;
    end else if (in_acc && in_action == ptu_pkg::ACT_READ && rd_hit) begin
      rd_en   = 1'b1;
      rd_addr = ptu_pkg::IDX_W'(in_entry_index);
    end

    wr_en   = 1'b0;
    wr_addr = ptu_pkg::IDX_W'(wr_ptr_r);
    wr_data = upd_ent;
    priority if (upd_vld && upd_keep) begin
      wr_en = 1'b1;
    end else if (in_acc && in_action == ptu_pkg::ACT_INSERT && !full) begin
      wr_en   = 1'b1;
      wr_addr = ptu_pkg::IDX_W'(count_r);
      wr_data = ins_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  ptu_update u_update (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (rd_vld_r),
    .in_ent   (rd_q_r),
    .dt       (dt_r),
    .cfg      (cfg_r),
    .out_vld  (upd_vld),
    .out_ent  (upd_ent),
    .out_keep (upd_keep)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_accepted    <= acc_r && (act_r == ptu_pkg::ACT_INSERT);
      out_live_count  <= ptu_pkg::OUT_CNT_W'(count_r);
      out_entry_valid <= hit_r && (act_r == ptu_pkg::ACT_READ);
      if (hit_r && act_r == ptu_pkg::ACT_READ) begin
        out_x    <= rd_q_r.pos_x;
        out_y    <= rd_q_r.pos_y;
        out_life <= rd_q_r.life;
        out_size <= rd_q_r.size;
        out_kind <= rd_q_r.kind;
      end else begin
        out_x    <= '0;
        out_y    <= '0;
        out_life <= '0;
        out_size <= '0;
        out_kind <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ptu_pkg::CNT_W'(ptu_pkg::CAPACITY))
    else $error("live count above capacity");

  a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK || state_r == S_DRAIN) |-> wr_ptr_r <= rd_ptr_r)
    else $error("compaction write overtook read pointer");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!rd_vld_r && !upd_vld))
    else $error("update pipeline busy while idle");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result loaded outside finish state");

endmodule

// File: tb/particle_table_checker.sv
`timescale 1ns / 1ps
// particle_table_checker: watches the input, result and register channels of the core,
// keeps its own copy of the particle table and compares every result field by field
// depends on ptu_pkg only

module particle_table_checker
  import ptu_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [ACT_W-1:0]           in_action,
  input  logic [DT_W-1:0]            in_step_time,
  input  logic signed [POS_W-1:0]    in_start_x,
  input  logic signed [POS_W-1:0]    in_start_y,
  input  logic signed [VEL_W-1:0]    in_speed_x,
  input  logic signed [VEL_W-1:0]    in_speed_y,
  input  logic [RATE_W-1:0]          in_fade_rate,
  input  logic [SIZE_W-1:0]          in_start_size,
  input  logic [KIND_W-1:0]          in_kind,
  input  logic [RIDX_W-1:0]          in_entry_index,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       out_accepted,
  input  logic [OUT_CNT_W-1:0]       out_live_count,
  input  logic                       out_entry_valid,
  input  logic signed [POS_W-1:0]    out_x,
  input  logic signed [POS_W-1:0]    out_y,
  input  logic [LIFE_W-1:0]          out_life,
  input  logic [SIZE_W-1:0]          out_size,
  input  logic [KIND_W-1:0]          out_kind,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CIDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  output int                         mismatches,
  output int                         pending
);

  typedef struct packed {
    logic                    accepted;
    logic [OUT_CNT_W-1:0]    live_count;
    logic                    entry_valid;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [LIFE_W-1:0]       life;
    logic [SIZE_W-1:0]       size;
    logic [KIND_W-1:0]       kind;
  } table_result_t;

  entry_t        particles [CAPACITY];
  int            live;
  cfg_t          regs;
  table_result_t awaited_q [$];

  function automatic logic signed [POS_W-1:0] clamp_pos(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[POS_W-1:0];
  endfunction

  // one euler step over the table, survivors packed down in order
  function automatic void advance_particles(logic [DT_W-1:0] dt);
    int               r;
    int               kept;
    entry_t           e;
    longint unsigned  fade;
    longint           step_x;
    longint           step_y;
    kept = 0;
    for (r = 0; r < live; r++) begin
      e = particles[r];
      fade = (64'(dt) * 64'(e.rate) + 64'd32768) >> 16;
      if (fade >= 64'(e.life)) e.life = '0;
      else e.life = e.life - LIFE_W'(fade);
      step_x = (longint'(e.vel_x) * longint'(dt) + 64'sd32768) >>> 16;
      step_y = (longint'(e.vel_y) * longint'(dt) + 64'sd32768) >>> 16;
      e.pos_x = clamp_pos(longint'(e.pos_x) + step_x);
      e.pos_y = clamp_pos(longint'(e.pos_y) + step_y);
      e.vel_x = VEL_W'((longint'(e.vel_x) * longint'(regs.velocity_keep) + 64'sd32768) >>> 16);
      e.vel_y = VEL_W'((longint'(e.vel_y) * longint'(regs.velocity_keep) + 64'sd32768) >>> 16);
      if (e.kind == KIND_FOAM)
        e.size = SIZE_W'((64'(e.size) * 64'(regs.foam_shrink) + 64'd32768) >> 16);
      if (e.life != '0 && e.size >= regs.min_size) begin
        particles[kept] = e;
        kept++;
      end
    end
    live = kept;
  endfunction

  function automatic table_result_t predict_outcome();
    table_result_t res;
    entry_t        e;
    res = '0;
    case (in_action)
      ACT_TICK: advance_particles(in_step_time);
      ACT_INSERT: begin
        if (live < CAPACITY) begin
          e.pos_x = in_start_x;
          e.pos_y = in_start_y;
          e.vel_x = in_speed_x;
          e.vel_y = in_speed_y;
          e.life  = LIFE_FULL;
          e.rate  = in_fade_rate;
          e.size  = in_start_size;
          e.kind  = in_kind;
          particles[live] = e;
          live++;
          res.accepted = 1'b1;
        end
      end
      ACT_CLEAR: live = 0;
      ACT_READ: begin
        if (int'(in_entry_index) < live) begin
          e = particles[in_entry_index];
          res.entry_valid = 1'b1;
          res.x    = e.pos_x;
          res.y    = e.pos_y;
          res.life = e.life;
          res.size = e.size;
          res.kind = e.kind;
        end
      end
      default: ;
    endcase
    res.live_count = OUT_CNT_W'(live);
    return res;
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("time %0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    table_result_t want;
    if (!rst_n) begin
      live = 0;
      regs = '{velocity_keep: VELOCITY_KEEP_RST, foam_shrink: FOAM_SHRINK_RST,
               min_size: MIN_SIZE_RST};
      awaited_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VELOCITY_KEEP: regs.velocity_keep = cfg_data;
          REG_FOAM_SHRINK:   regs.foam_shrink = cfg_data;
          REG_MIN_SIZE:      regs.min_size = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        awaited_q = {awaited_q, predict_outcome()};
      if (out_valid && !out_stall) begin
        if (awaited_q.size() == 0) begin
          mismatches++;
          $display("time %0t: result with no transaction waiting", $time);
        end else begin
          want = awaited_q.pop_front();
          check_field("accepted", want.accepted, out_accepted);
          check_field("live_count", want.live_count, out_live_count);
          check_field("entry_valid", want.entry_valid, out_entry_valid);
          check_field("x", want.x, out_x);
          check_field("y", want.y, out_y);
          check_field("life", want.life, out_life);
          check_field("size", want.size, out_size);
          check_field("kind", want.kind, out_kind);
        end
      end
    end
    pending <= awaited_q.size();
  end

endmodule

// File: tb/particle_table_update_core_tb.sv
`timescale 1ns / 1ps
// particle_table_update_core_tb: directed and random inserts, ticks, reads, clears and
// register settings under bursty and steady sending and patterned result stalls
// depends on ptu_pkg, particle_table_update_core and particle_table_checker

module particle_table_update_core_tb;
  import ptu_pkg::*;

  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 100;
  localparam int PHASE_ITEMS   = 110;
  localparam int PHASES        = 5;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic [DT_W-1:0]         dt;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic [RATE_W-1:0]       rate;
    logic [SIZE_W-1:0]       size;
    logic [KIND_W-1:0]       kind;
    logic [RIDX_W-1:0]       idx;
  } particle_cmd_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [ACT_W-1:0]        in_action;
  logic [DT_W-1:0]         in_step_time;
  logic signed [POS_W-1:0] in_start_x;
  logic signed [POS_W-1:0] in_start_y;
  logic signed [VEL_W-1:0] in_speed_x;
  logic signed [VEL_W-1:0] in_speed_y;
  logic [RATE_W-1:0]       in_fade_rate;
  logic [SIZE_W-1:0]       in_start_size;
  logic [KIND_W-1:0]       in_kind;
  logic [RIDX_W-1:0]       in_entry_index;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_accepted;
  logic [OUT_CNT_W-1:0]    out_live_count;
  logic                    out_entry_valid;
  logic signed [POS_W-1:0] out_x;
  logic signed [POS_W-1:0] out_y;
  logic [LIFE_W-1:0]       out_life;
  logic [SIZE_W-1:0]       out_size;
  logic [KIND_W-1:0]       out_kind;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CIDX_W-1:0]       cfg_index;
  logic [CFG_W-1:0]        cfg_data;

  logic hold_req;
  int   mismatches;
  int   pending;
  int   burst_left;
  bit   steady;

  particle_table_update_core dut (.*);

  particle_table_checker table_check (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side stall pattern, with one long hold-off on request
  initial begin
    int seg;
    int pct;
    bit hold_taken;
    out_stall = 1'b0;
    hold_taken = 1'b0;
    forever begin
      seg = $urandom_range(10, 150);
      case ($urandom_range(0, 3))
        0: pct = 0;
        1: pct = 20;
        2: pct = 50;
        default: pct = 85;
      endcase
      repeat (seg) begin
        @(posedge clk);
        if (hold_req && !hold_taken) begin
          hold_taken = 1'b1;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("** particle_table_update_core: FAILED **");
    $finish;
  end

  function automatic particle_cmd_t noise_cmd(logic [ACT_W-1:0] act);
    particle_cmd_t c;
    c.action = act;
    c.dt     = DT_W'($urandom);
    c.x      = $urandom;
    c.y      = $urandom;
    c.vx     = VEL_W'($urandom);
    c.vy     = VEL_W'($urandom);
    c.rate   = RATE_W'($urandom);
    c.size   = SIZE_W'($urandom);
    c.kind   = KIND_W'($urandom);
    c.idx    = RIDX_W'($urandom);
    return c;
  endfunction

  function automatic particle_cmd_t tick_cmd(logic [DT_W-1:0] dt);
    particle_cmd_t c;
    c = noise_cmd(ACT_TICK);
    c.dt = dt;
    return c;
  endfunction

  function automatic particle_cmd_t read_cmd(logic [RIDX_W-1:0] idx);
    particle_cmd_t c;
    c = noise_cmd(ACT_READ);
    c.idx = idx;
    return c;
  endfunction

  function automatic particle_cmd_t insert_cmd(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                               logic [VEL_W-1:0] vx, logic [VEL_W-1:0] vy,
                                               logic [RATE_W-1:0] rate,
                                               logic [SIZE_W-1:0] size,
                                               logic [KIND_W-1:0] kind);
    particle_cmd_t c;
    c = noise_cmd(ACT_INSERT);
    c.x = x;
    c.y = y;
    c.vx = vx;
    c.vy = vy;
    c.rate = rate;
    c.size = size;
    c.kind = kind;
    return c;
  endfunction

  function automatic particle_cmd_t random_cmd(int insert_pct);
    particle_cmd_t c;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < insert_pct) begin
      c = noise_cmd(ACT_INSERT);
      if ($urandom_range(0, 1)) c.x = c.x >>> 12;
      if ($urandom_range(0, 1)) c.y = c.y >>> 12;
      if ($urandom_range(0, 1)) c.vx = c.vx >>> 6;
      if ($urandom_range(0, 1)) c.vy = c.vy >>> 6;
      roll = $urandom_range(0, 99);
      if (roll < 25) c.rate = '0;
      else if (roll < 70) c.rate = RATE_W'($urandom_range(1, 600));
      else if (roll < 95) c.rate = RATE_W'($urandom);
      else c.rate = '1;
      roll = $urandom_range(0, 99);
      if (roll < 40) c.size = SIZE_W'($urandom_range(256, 4096));
      else if (roll < 60) c.size = SIZE_W'($urandom_range(0, 255));
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        c = noise_cmd(ACT_READ);
        if ($urandom_range(0, 1)) c.idx = RIDX_W'($urandom_range(0, 15));
      end else if (roll < 94) begin
        c = noise_cmd(ACT_TICK);
        case ($urandom_range(0, 9))
          0: c.dt = '0;
          1: c.dt = '1;
          2, 3, 4: ;
          default: c.dt = DT_W'($urandom_range(1, 2000));
        endcase
      end else begin
        c = noise_cmd(ACT_CLEAR);
      end
    end
    return c;
  endfunction

  task automatic send(particle_cmd_t c);
    in_valid       <= 1'b1;
    in_action      <= c.action;
    in_step_time   <= c.dt;
    in_start_x     <= c.x;
    in_start_y     <= c.y;
    in_speed_x     <= c.vx;
    in_speed_y     <= c.vy;
    in_fade_rate   <= c.rate;
    in_start_size  <= c.size;
    in_kind        <= c.kind;
    in_entry_index <= c.idx;
    do @(posedge clk); while (in_stall);
  endtask

  // bursts of random length separated by random gaps, unless sending is steady
  task automatic pace();
    int gap;
    if (!steady) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap = $urandom_range(0, 12);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 20);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_regs(logic [CFG_W-1:0] keep, logic [CFG_W-1:0] shrink,
                            logic [CFG_W-1:0] min_sz);
    logic [CIDX_W-1:0] which [3];
    logic [CFG_W-1:0]  vals [3];
    which = '{REG_VELOCITY_KEEP, REG_FOAM_SHRINK, REG_MIN_SIZE};
    vals = '{keep, shrink, min_sz};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= which[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int insert_pct;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_TICK;
    in_step_time = '0;
    in_start_x = '0;
    in_start_y = '0;
    in_speed_x = '0;
    in_speed_y = '0;
    in_fade_rate = '0;
    in_start_size = '0;
    in_kind = '0;
    in_entry_index = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_VELOCITY_KEEP;
    cfg_data = '0;
    hold_req = 1'b0;
    burst_left = 0;
    steady = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, extremes, every kind, exact size threshold
    send(read_cmd('0));
    send(tick_cmd(16'd1000));
    send(insert_cmd(32'h7fffffff, 32'h80000000, 24'h7fffff, 24'h800000, '0, 16'hffff, 2'd0));
    send(insert_cmd(32'h80000000, 32'h7fffffff, 24'h800000, 24'h7fffff, '1, 16'h0000, 2'd1));
    send(insert_cmd('0, '0, 24'h010000, 24'hff0000, 17'd1, 16'd128, 2'd1));
    send(insert_cmd(32'h00010000, 32'hffff0000, 24'h000800, 24'hfff800, 17'd65536,
                    16'd200, 2'd2));
    send(insert_cmd(32'h12345678, 32'h87654321, 24'h123456, 24'h876543, 17'd300,
                    16'h1000, 2'd3));
    for (int i = 0; i < 5; i++) send(read_cmd(RIDX_W'(i)));
    send(read_cmd(6'd63));
    send(tick_cmd('0));
    send(read_cmd(6'd0));
    send(read_cmd(6'd1));
    send(tick_cmd('1));
    send(read_cmd(6'd0));
    send(read_cmd(6'd1));
    send(read_cmd(6'd2));
    send(noise_cmd(ACT_CLEAR));
    send(read_cmd(6'd0));
    send(random_cmd(100));
    send(read_cmd(6'd0));
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        1: write_regs('1, '1, '0);
        2: write_regs('0, '0, '1);
        3: write_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom_range(0, 1024)));
        4: write_regs(VELOCITY_KEEP_RST, FOAM_SHRINK_RST, MIN_SIZE_RST);
        default: ;
      endcase
      case (phase)
        0: insert_pct = 80;
        1: insert_pct = 55;
        2: insert_pct = 50;
        3: insert_pct = 45;
        default: insert_pct = 60;
      endcase
      steady = (phase == PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 1 && n == 30) hold_req <= 1'b1;
        if (phase == 2 && n == 50) drain();
        pace();
        send(random_cmd(insert_pct));
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("** particle_table_update_core: PASSED **");
    else
      $display("** particle_table_update_core: FAILED **");
    $finish;
  end

endmodule
